### hdl/rotation_matrix_to_cardan_angles_core_defines.svh
// Assertion macros shared by the Cardan angle core RTL.
// Bodies sample on clk_i and are disabled while rst_ni is low.
`ifndef ROTATION_MATRIX_TO_CARDAN_ANGLES_CORE_DEFINES_SVH
`define ROTATION_MATRIX_TO_CARDAN_ANGLES_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RMCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RMCA_ASSERT_HOLD(lbl, cond, sig, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error(msg);
`else
`define RMCA_ASSERT(lbl, prop, msg)
`define RMCA_ASSERT_HOLD(lbl, cond, sig, msg)
`endif
`endif

### hdl/rmca_pkg.sv
// Package for the Cardan angle core: widths, constants, the arctangent table
// and the structs passed along the pipeline. Depends on nothing.
`timescale 1ns / 1ps
package rmca_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = DATA_WIDTH - 1;
  localparam int SQ_W       = 2 * DATA_WIDTH - 1;
  localparam int MAG_W      = DATA_WIDTH;
  localparam int EPS_W      = 15;
  localparam int ANG_W      = 16;
  localparam int STEPS      = 16;
  localparam int XY_W       = 36;
  localparam int Z_W        = 20;
  localparam int SCALE_SH   = 32 - DATA_WIDTH;
  localparam int LAT        = 1 + STEPS + STEPS + 1 + STEPS + STEPS + 1;

  localparam logic [SQ_W-1:0]      ONE_SQ      = SQ_W'(1) << (2 * FRAC_BITS);
  localparam logic [MAG_W-1:0]     ONE         = MAG_W'(1) << FRAC_BITS;
  localparam logic signed [Z_W-1:0] HALF_PI_Q16 = Z_W'(102944);
  localparam logic [ANG_W-2:0]     PI_Q13      = (ANG_W - 1)'(25736);

  typedef struct packed {
    logic             sing;
    logic             neg_a;
    logic             neg_b;
    logic             neg_g;
    logic             neg_ca;
    logic             neg_cg;
    logic [MAG_W-1:0] mag22;
    logic [MAG_W-1:0] mag00;
  } front_t;

  typedef struct packed {
    logic sing;
    logic neg_a;
    logic neg_b;
    logic neg_g;
    logic neg_ca;
    logic neg_cg;
  } flags_t;

  typedef struct packed {
    logic [MAG_W-1:0] cb;
    flags_t           fl;
  } side_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] m;
    flags_t                fl;
  } lane_t;

  function automatic logic [MAG_W-1:0] mag_of(logic signed [DATA_WIDTH-1:0] v);
    return v[DATA_WIDTH-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic logic [16:0] atan_q16(int i);
    logic [16:0] r;
    case (i)
      0:       r = 17'd51472;
      1:       r = 17'd30386;
      2:       r = 17'd16055;
      3:       r = 17'd8150;
      4:       r = 17'd4091;
      5:       r = 17'd2047;
      6:       r = 17'd1024;
      7:       r = 17'd512;
      8:       r = 17'd256;
      9:       r = 17'd128;
      10:      r = 17'd64;
      11:      r = 17'd32;
      12:      r = 17'd16;
      13:      r = 17'd8;
      14:      r = 17'd4;
      15:      r = 17'd2;
      default: r = 17'd0;
    endcase
    return r;
  endfunction

endpackage

### hdl/rmca_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on rmca_pkg.
`timescale 1ns / 1ps
module rmca_isqrt import rmca_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SQ_W-1:0]  val_i,
  output logic [MAG_W-1:0] root_o
);

  localparam int RW = SQ_W + 1;

  logic [RW-1:0] rem_q [STEPS];
  logic [RW-1:0] res_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_st
    localparam logic [RW-1:0] BITV = RW'(1) << (SQ_W - 1 - 2 * i);
    logic [RW-1:0] rin;
    logic [RW-1:0] sin;
    logic [RW-1:0] t;
    if (i == 0) begin : g_first
      assign rin = RW'(val_i);
      assign sin = '0;
    end else begin : g_next
      assign rin = rem_q[i-1];
      assign sin = res_q[i-1];
    end
    assign t = sin + BITV;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rin >= t) begin
          rem_q[i] <= rin - t;
          res_q[i] <= (sin >> 1) + BITV;
        end else begin
          rem_q[i] <= rin;
          res_q[i] <= sin >> 1;
        end
      end
    end
  end

  assign root_o = res_q[STEPS-1][MAG_W-1:0];

endmodule

### hdl/rmca_div.sv
// Pipelined restoring divider giving min(mag * 2^15 / den, 2^15).
// Depends on rmca_pkg.
`timescale 1ns / 1ps
module rmca_div import rmca_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [MAG_W-1:0] mag_i,
  input  logic [MAG_W-1:0] den_i,
  output logic [MAG_W-1:0] quo_o
);

  logic [MAG_W-1:0] rem_q  [STEPS];
  logic [MAG_W-1:0] quo_q  [STEPS];
  logic [MAG_W-1:0] den_q  [STEPS];
  logic             sat_q  [STEPS];
  logic             zero_q [STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_st
    logic [MAG_W-1:0] rin;
    logic [MAG_W-1:0] qin;
    logic [MAG_W-1:0] din;
    logic             nbit;
    logic             sin;
    logic             zin;
    logic [MAG_W:0]   sh;
    if (i == 0) begin : g_first
      assign rin  = {1'b0, mag_i[MAG_W-1:1]};
      assign qin  = '0;
      assign din  = den_i;
      assign nbit = mag_i[0];
      assign sin  = mag_i > den_i;
      assign zin  = mag_i == '0;
    end else begin : g_next
      assign rin  = rem_q[i-1];
      assign qin  = quo_q[i-1];
      assign din  = den_q[i-1];
      assign nbit = 1'b0;
      assign sin  = sat_q[i-1];
      assign zin  = zero_q[i-1];
    end
    assign sh = {rin, nbit};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[i]  <= din;
        sat_q[i]  <= sin;
        zero_q[i] <= zin;
        if (sh >= {1'b0, din}) begin
          rem_q[i] <= MAG_W'(sh - {1'b0, din});
          quo_q[i] <= {qin[MAG_W-2:0], 1'b1};
        end else begin
          rem_q[i] <= MAG_W'(sh);
          quo_q[i] <= {qin[MAG_W-2:0], 1'b0};
        end
      end
    end
  end

  assign quo_o = sat_q[STEPS-1]  ? ONE :
                 zero_q[STEPS-1] ? '0  : quo_q[STEPS-1];

endmodule

### hdl/rmca_cordic.sv
// Pipelined CORDIC arccosine from a cosine and sine magnitude, with sign,
// rounding to Q3.13 and singular zeroing. Depends on rmca_pkg.
`timescale 1ns / 1ps
module rmca_cordic import rmca_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [MAG_W-1:0]        cmag_i,
  input  logic                    cneg_i,
  input  logic [MAG_W-1:0]        smag_i,
  input  logic                    aneg_i,
  input  logic                    sing_i,
  output logic signed [ANG_W-1:0] angle_o,
  output logic                    sing_o
);

  logic signed [XY_W-1:0] x_q [STEPS];
  logic signed [XY_W-1:0] y_q [STEPS];
  logic signed [Z_W-1:0]  z_q [STEPS];
  logic                   an_q [STEPS];
  logic                   sg_q [STEPS];

  logic signed [XY_W-1:0] xm;
  logic signed [XY_W-1:0] xc;
  logic signed [XY_W-1:0] ys;
  logic signed [XY_W-1:0] x0;
  logic signed [XY_W-1:0] y0;
  logic signed [Z_W-1:0]  z0;

  always_comb begin
    xm = $signed({{(XY_W - MAG_W){1'b0}}, cmag_i}) <<< SCALE_SH;
    ys = $signed({{(XY_W - MAG_W){1'b0}}, smag_i}) <<< SCALE_SH;
    xc = cneg_i ? -xm : xm;
    if (xc < 0) begin
      x0 = ys;
      y0 = -xc;
      z0 = HALF_PI_Q16;
    end else begin
      x0 = xc;
      y0 = ys;
      z0 = '0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_st
    localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q16(i));
    logic signed [XY_W-1:0] xi;
    logic signed [XY_W-1:0] yi;
    logic signed [Z_W-1:0]  zi;
    logic                   ai;
    logic                   si;
    if (i == 0) begin : g_first
      assign xi = x0;
      assign yi = y0;
      assign zi = z0;
      assign ai = aneg_i;
      assign si = sing_i;
    end else begin : g_next
      assign xi = x_q[i-1];
      assign yi = y_q[i-1];
      assign zi = z_q[i-1];
      assign ai = an_q[i-1];
      assign si = sg_q[i-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        an_q[i] <= ai;
        sg_q[i] <= si;
        if (yi > 0) begin
          x_q[i] <= xi + (yi >>> i);
          y_q[i] <= yi - (xi >>> i);
          z_q[i] <= zi + ATAN;
        end else begin
          x_q[i] <= xi - (yi >>> i);
          y_q[i] <= yi + (xi >>> i);
          z_q[i] <= zi - ATAN;
        end
      end
    end
  end

  logic signed [Z_W-1:0] zc;
  logic [Z_W-1:0]        rnd;
  logic [ANG_W-2:0]      rc;

  always_comb begin
    zc  = (z_q[STEPS-1] < 0) ? '0 : z_q[STEPS-1];
    rnd = (Z_W'(zc) + Z_W'(4)) >> 3;
    rc  = (rnd > Z_W'(PI_Q13)) ? PI_Q13 : rnd[ANG_W-2:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sing_o <= sg_q[STEPS-1];
      if (sg_q[STEPS-1]) begin
        angle_o <= '0;
      end else if (an_q[STEPS-1]) begin
        angle_o <= -$signed({1'b0, rc});
      end else begin
        angle_o <= $signed({1'b0, rc});
      end
    end
  end

endmodule

### hdl/rotation_matrix_to_cardan_angles_core.sv
// Cardan angles from a rotation matrix, one matrix per cycle unless a result
// waits; the depth comes from the input register (1), the cosine square root (16),
// the two dividers (16), the sine square register (1), the sine square roots (16)
// and the CORDIC arccosine (17).
// The whole pipeline advances together and stalls only while a result waits.
// rst_ni clears valid bits and sets eps_threshold to 1. Uses rmca_pkg.
`timescale 1ns / 1ps
`include "rotation_matrix_to_cardan_angles_core_defines.svh"
module rotation_matrix_to_cardan_angles_core import rmca_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [EPS_W-1:0] cfg_data_i,     // eps_threshold
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [79:0]      s_axis_tdata,   // r00, r01, r02, r12, r22
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // alpha_angle, beta_angle, gamma_angle
  output logic             m_axis_tuser    // singular_flag
);

  logic [EPS_W-1:0] eps_q;
  logic [LAT-1:0]   valid_q;
  logic             en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_W'(1);
    end else if (cfg_valid_i) begin
      eps_q <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  assign en            = !valid_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = valid_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // front stage
  logic signed [DATA_WIDTH-1:0] r00, r01, r02, r12, r22;
  logic [MAG_W-1:0]             mag02;
  logic [MAG_W:0]               margin;
  logic [31:0]                  sq02;
  front_t                       front_d, front_q;
  logic [SQ_W-1:0]              v0_d, v0_q;

  always_comb begin
    r00   = s_axis_tdata[15:0];
    r01   = s_axis_tdata[31:16];
    r02   = s_axis_tdata[47:32];
    r12   = s_axis_tdata[63:48];
    r22   = s_axis_tdata[79:64];
    mag02 = mag_of(r02);
    margin = (MAG_W + 1)'(ONE) - (MAG_W + 1)'(mag02);
    sq02  = 32'(mag02) * 32'(mag02);
    v0_d  = SQ_W'(32'(ONE_SQ) - sq02);
    front_d.sing   = margin < (MAG_W + 1)'(eps_q);
    front_d.neg_a  = !r12[DATA_WIDTH-1] && (r12 != '0);
    front_d.neg_b  = r02[DATA_WIDTH-1];
    front_d.neg_g  = !r01[DATA_WIDTH-1] && (r01 != '0);
    front_d.neg_ca = r22[DATA_WIDTH-1];
    front_d.neg_cg = r00[DATA_WIDTH-1];
    front_d.mag22  = mag_of(r22);
    front_d.mag00  = mag_of(r00);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      front_q <= front_d;
      v0_q    <= v0_d;
    end
  end

  // cosine of beta
  logic [MAG_W-1:0] cb;
  front_t           fr_dly_q [STEPS];

  rmca_isqrt u_sqrt_cb (.clk_i(clk_i), .en_i(en), .val_i(v0_q), .root_o(cb));

  always_ff @(posedge clk_i) begin
    if (en) begin
      fr_dly_q[0] <= front_q;
      for (int k = 1; k < STEPS; k++) begin
        fr_dly_q[k] <= fr_dly_q[k-1];
      end
    end
  end

  // cosine ratios
  front_t           fr;
  side_t            side_d;
  side_t            side_q [STEPS];
  logic [MAG_W-1:0] ca_mag, cg_mag;

  assign fr = fr_dly_q[STEPS-1];

  rmca_div u_div_a (.clk_i(clk_i), .en_i(en), .mag_i(fr.mag22), .den_i(cb), .quo_o(ca_mag));
  rmca_div u_div_g (.clk_i(clk_i), .en_i(en), .mag_i(fr.mag00), .den_i(cb), .quo_o(cg_mag));

  always_comb begin
    side_d.cb        = cb;
    side_d.fl.sing   = fr.sing;
    side_d.fl.neg_a  = fr.neg_a;
    side_d.fl.neg_b  = fr.neg_b;
    side_d.fl.neg_g  = fr.neg_g;
    side_d.fl.neg_ca = fr.neg_ca;
    side_d.fl.neg_cg = fr.neg_cg;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < STEPS; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // sine squares
  lane_t           lane_d, lane_q;
  logic [SQ_W-1:0] v2_d [3];
  logic [SQ_W-1:0] v2_q [3];

  always_comb begin
    lane_d.m[0] = ca_mag;
    lane_d.m[1] = side_q[STEPS-1].cb;
    lane_d.m[2] = cg_mag;
    lane_d.fl   = side_q[STEPS-1].fl;
    for (int k = 0; k < 3; k++) begin
      v2_d[k] = SQ_W'(32'(ONE_SQ) - 32'(lane_d.m[k]) * 32'(lane_d.m[k]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lane_q <= lane_d;
      for (int k = 0; k < 3; k++) begin
        v2_q[k] <= v2_d[k];
      end
    end
  end

  // sines and arccosines
  logic [MAG_W-1:0]        smag [3];
  lane_t                   ln_dly_q [STEPS];
  lane_t                   ln;
  logic signed [ANG_W-1:0] alpha_angle, beta_angle, gamma_angle;
  logic                    sing_out;

  for (genvar j = 0; j < 3; j++) begin : g_sin
    rmca_isqrt u_sqrt_s (.clk_i(clk_i), .en_i(en), .val_i(v2_q[j]), .root_o(smag[j]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ln_dly_q[0] <= lane_q;
      for (int k = 1; k < STEPS; k++) begin
        ln_dly_q[k] <= ln_dly_q[k-1];
      end
    end
  end

  assign ln = ln_dly_q[STEPS-1];

  rmca_cordic u_cordic_a (
    .clk_i(clk_i), .en_i(en), .cmag_i(ln.m[0]), .cneg_i(ln.fl.neg_ca), .smag_i(smag[0]),
    .aneg_i(ln.fl.neg_a), .sing_i(ln.fl.sing), .angle_o(alpha_angle), .sing_o(sing_out)
  );
  rmca_cordic u_cordic_b (
    .clk_i(clk_i), .en_i(en), .cmag_i(ln.m[1]), .cneg_i(1'b0), .smag_i(smag[1]),
    .aneg_i(ln.fl.neg_b), .sing_i(ln.fl.sing), .angle_o(beta_angle), .sing_o()
  );
  rmca_cordic u_cordic_g (
    .clk_i(clk_i), .en_i(en), .cmag_i(ln.m[2]), .cneg_i(ln.fl.neg_cg), .smag_i(smag[2]),
    .aneg_i(ln.fl.neg_g), .sing_i(ln.fl.sing), .angle_o(gamma_angle), .sing_o()
  );

  assign m_axis_tdata = {gamma_angle, beta_angle, alpha_angle};
  assign m_axis_tuser = sing_out;

  `RMCA_ASSERT(a_sing_zero, (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0), "singular result with nonzero angles")
  `RMCA_ASSERT(a_range, m_axis_tvalid |-> ((alpha_angle <= 16'sd25736) && (alpha_angle >= -16'sd25736) && (gamma_angle <= 16'sd25736) && (gamma_angle >= -16'sd25736)), "angle out of range")
  `RMCA_ASSERT_HOLD(a_stall_hold, !en, valid_q, "pipeline moved during stall")

endmodule

### tb/rotation_matrix_to_cardan_angles_core_tb.sv
// Testbench for rotation_matrix_to_cardan_angles_core: directed and random matrices
// checked against an in-bench fixed-point predictor with random stream stalls.
// Depends on rmca_pkg and the core RTL.
`timescale 1ns / 1ps
module rotation_matrix_to_cardan_angles_core_tb;
  import rmca_pkg::*;

  localparam int UNIT      = 32768;
  localparam int DRAIN_CYC = LAT + 20;
  localparam int MAX_CYC   = 400000;

  typedef struct {
    logic [15:0] alpha;
    logic [15:0] beta;
    logic [15:0] gamma;
    logic        sing;
  } angles_t;

  typedef struct {
    logic signed [15:0] r00, r01, r02, r12, r22;
    bit                 typed;
    angles_t            exp_val;
  } row_t;

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             cfg_valid_i = 0;
  logic             cfg_ready_o;
  logic [EPS_W-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid = 0;
  logic             s_axis_tready;
  logic [79:0]      s_axis_tdata = '0;   // r00, r01, r02, r12, r22
  logic             m_axis_tvalid;
  logic             m_axis_tready = 0;
  logic [47:0]      m_axis_tdata;        // alpha_angle, beta_angle, gamma_angle
  logic             m_axis_tuser;        // singular_flag

  rotation_matrix_to_cardan_angles_core dut (.*);

  angles_t   angle_queue[$];
  int        eps_reg = 1;
  int        errors = 0;
  int        n_sent = 0, n_recv = 0, n_sing = 0;
  longint    cycles = 0;
  bit        hold_req = 0;
  bit        sent_all = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint isqrt(longint v);
    longint res, bitv;
    res = 0;
    bitv = 64'sd1 << 62;
    while (bitv > v) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  function automatic longint cos_arg(longint num, longint den);
    longint mag, q;
    mag = num < 0 ? -num : num;
    if (den == 0) q = mag != 0 ? UNIT : 0;
    else q = (mag << 15) / den;
    if (q > UNIT) q = UNIT;
    return num < 0 ? -q : q;
  endfunction

  function automatic logic [15:0] arccos_q13(longint c, bit neg);
    longint s, x, y, z, xs, ys, t, r;
    s = isqrt(longint'(UNIT) * UNIT - c * c);
    x = c <<< 16;
    y = s <<< 16;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 102944;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys;
        y -= xs;
        z += longint'(atan_q16(i));
      end else begin
        x -= ys;
        y += xs;
        z -= longint'(atan_q16(i));
      end
    end
    if (z < 0) z = 0;
    r = (z + 4) >>> 3;
    if (r > 25736) r = 25736;
    if (neg) r = -r;
    return r[15:0];
  endfunction

  function automatic angles_t cardan_angles(row_t m);
    angles_t a;
    longint mag02, cb;
    mag02 = m.r02 < 0 ? -longint'(m.r02) : longint'(m.r02);
    if (UNIT - mag02 < eps_reg) begin
      a = '{16'd0, 16'd0, 16'd0, 1'b1};
      return a;
    end
    cb = isqrt(longint'(UNIT) * UNIT - longint'(m.r02) * m.r02);
    a.alpha = arccos_q13(cos_arg(m.r22, cb), m.r12 > 0);
    a.beta  = arccos_q13(cb, m.r02 < 0);
    a.gamma = arccos_q13(cos_arg(m.r00, cb), m.r01 > 0);
    a.sing  = 1'b0;
    return a;
  endfunction

  task automatic send_matrix(row_t m);
    int gap;
    angles_t exp_a;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {m.r22, m.r12, m.r02, m.r01, m.r00};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    exp_a = m.typed ? m.exp_val : cardan_angles(m);
    angle_queue.insert(angle_queue.size(), exp_a);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_and_write(int eps);
    s_axis_tvalid <= 1'b0;
    while (angle_queue.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYC) @(negedge clk_i);
    cfg_data_i  <= EPS_W'(eps);
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    eps_reg = eps;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [15:0] within_cb(longint cb);
    longint v;
    v = $urandom_range(0, 32'(cb));
    return 16'($urandom_range(0, 1) ? -v : v);
  endfunction

  function automatic row_t random_matrix();
    row_t m;
    longint cb;
    int kind;
    kind = $urandom_range(0, 9);
    m.typed = 0;
    m = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
          0, '{0, 0, 0, 0}};
    if (kind == 8) m.r02 = 16'($urandom_range(0, 1) ? -(UNIT - $urandom_range(0, 40))
                                                    : (UNIT - 1 - $urandom_range(0, 40)));
    if (kind == 9) m.r02 = -16'sd32768;
    if (kind <= 5) begin
      cb = isqrt(longint'(UNIT) * UNIT - longint'(m.r02) * m.r02);
      if (cb > 32767) cb = 32767;
      m.r00 = within_cb(cb);
      m.r01 = within_cb(cb);
      m.r12 = within_cb(cb);
      m.r22 = within_cb(cb);
    end
    return m;
  endfunction

  row_t directed[$] = '{
    '{16'sd32767, 16'sd0, 16'sd0, 16'sd0, 16'sd32767, 0, '{0, 0, 0, 0}},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0, '{0, 0, 0, 0}},
    '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 0, '{0, 0, 0, 0}},
    '{-16'sd32768, -16'sd32768, -16'sd32767, -16'sd32768, -16'sd32768, 0, '{0, 0, 0, 0}},
    '{16'sd1000, 16'sd5, -16'sd32768, -16'sd7, 16'sd3, 1, '{16'd0, 16'd0, 16'd0, 1'b1}},
    '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1,
      '{16'd0, 16'd0, 16'd0, 1'b1}},
    '{16'sd100, -16'sd100, 16'sd32766, 16'sd100, -16'sd100, 0, '{0, 0, 0, 0}},
    '{16'sd23170, 16'sd23170, 16'sd0, -16'sd23170, 16'sd23170, 0, '{0, 0, 0, 0}},
    '{-16'sd23170, -16'sd23170, 16'sd16384, 16'sd23170, -16'sd23170, 0, '{0, 0, 0, 0}},
    '{16'sd0, 16'sd32767, -16'sd16384, -16'sd32768, 16'sd0, 0, '{0, 0, 0, 0}},
    '{-16'sd32768, 16'sd1, 16'sd32000, -16'sd1, -16'sd32768, 0, '{0, 0, 0, 0}},
    '{16'sd32767, -16'sd1, -16'sd32000, 16'sd1, 16'sd32767, 0, '{0, 0, 0, 0}},
    '{16'sd28377, -16'sd16384, 16'sd8192, 16'sd4096, -16'sd30000, 0, '{0, 0, 0, 0}}
  };

  int eps_plan[4] = '{0, 32767, 0, 0};

  initial begin
    row_t m;
    eps_plan[2] = $urandom_range(1, 32766);
    eps_plan[3] = $urandom_range(1, 64);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (directed[i]) send_matrix(directed[i]);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) drain_and_write(eps_plan[ph-1]);
      if (ph == 1) begin
        m = '{16'sd5, -16'sd9, -16'sd32768, 16'sd3, -16'sd2, 0, '{0, 0, 0, 0}};
        send_matrix(m);
        m = '{16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 0, '{0, 0, 0, 0}};
        send_matrix(m);
      end
      if (ph == 2) hold_req = 1;
      for (int i = 0; i < 255; i++) send_matrix(random_matrix());
    end
    s_axis_tvalid <= 1'b0;
    sent_all = 1;
  end

  initial begin
    int mode, len;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      mode = $urandom_range(0, 3);
      len = $urandom_range(5, 60);
      repeat (len) begin
        @(negedge clk_i);
        case (mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= $urandom_range(0, 1);
          2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    angles_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_recv++;
      if (angle_queue.size() == 0) begin
        $display("%0t: unexpected result %h sing %b", $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        e = angle_queue.pop_front();
        if (e.sing) n_sing++;
        if (m_axis_tdata !== {e.gamma, e.beta, e.alpha} || m_axis_tuser !== e.sing) begin
          $display("%0t: expected a %h b %h g %h sing %b, actual a %h b %h g %h sing %b",
                   $time, e.alpha, e.beta, e.gamma, e.sing, m_axis_tdata[15:0],
                   m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > MAX_CYC) begin
        $display("Verification failed");
        $finish;
      end
      if (sent_all && angle_queue.size() == 0) begin
        repeat (DRAIN_CYC) @(posedge clk_i);
        if (angle_queue.size() != 0) errors++;
        $display("Sent %0d matrices, checked %0d results (%0d singular)", n_sent, n_recv,
                 n_sing);
        $display("Threshold settings: 1, 0, 32767 and two mid values; long output hold-off");
        if (errors == 0) begin
          $display("Verification passed");
        end else begin
          $display("Verification failed");
        end
        $finish;
      end
    end
  end

endmodule
